// ===== sv/tscbr_pkg.sv =====
package tscbr_pkg;

   localparam int CAPACITY            = 32768;
   localparam int MAX_TS_PER_DATAGRAM = 16;
   localparam int SLOT_W              = $clog2(CAPACITY);
   localparam int COUNT_W             = 16;
   localparam int TPD_W               = 5;
   localparam int RATE_W              = 30;
   localparam int US_W                = 10;
   localparam int PROD_W              = RATE_W + US_W;
   localparam int CREDIT_W            = 48;
   localparam int COST_W              = 35;
   localparam int CSR_IDX_W           = 3;
   localparam int CSR_DATA_W          = 30;

   localparam logic [RATE_W-1:0]  RATE_MAX   = 30'd1000000000;
   localparam logic [RATE_W-1:0]  RATE_RESET = 30'd100000000;
   localparam logic [COST_W-1:0]  TS_COST    = 35'd1504000000;  // 188 bytes * 8 * 1e6 us
   localparam logic [31:0]        NULL_WORD  = 32'h471F_FF10;

   localparam logic [CSR_IDX_W-1:0] REG_BITRATE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TPD       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SLOTS     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ACC_EMPTY = 3'd4;

   localparam logic [1:0] KIND_REPLY  = 2'd0;
   localparam logic [1:0] KIND_CACHED = 2'd1;
   localparam logic [1:0] KIND_NULL   = 2'd2;

   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ARRIVE,
      ST_MUL,
      ST_ADD,
      ST_DECIDE,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic [RATE_W-1:0]  bitrate;
      logic [TPD_W-1:0]   tpd;
      logic [COUNT_W-1:0] slots;
      logic [COUNT_W-1:0] threshold;
      logic               acc_empty;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic arrive;
      logic mul;
      logic add;
      logic decide;
      logic send;
   } cmd_type;

   typedef struct packed {
      logic credit_pos;
      logic send_last;
   } status_type;

endpackage

// ===== sv/tscbr_csr.sv =====
module tscbr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tscbr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tscbr_pkg::CSR_DATA_W-1:0]    csr_data,
   output tscbr_pkg::cfg_type                  cfg_out
);
   import tscbr_pkg::*;

   logic [RATE_W-1:0]  bitrate_ff;
   logic [TPD_W-1:0]   tpd_ff;
   logic [COUNT_W-1:0] slots_ff;
   logic [COUNT_W-1:0] threshold_ff;
   logic               acc_empty_ff;
   logic               write_en;

   assign csr_ready = 1'b1;
   assign write_en  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bitrate_ff   <= RATE_RESET;
         tpd_ff       <= TPD_W'(7);
         slots_ff     <= COUNT_W'(30000);
         threshold_ff <= COUNT_W'(10000);
         acc_empty_ff <= 1'b0;
      end else if (write_en) begin
         unique case (csr_index)
            REG_BITRATE:   bitrate_ff   <= csr_data[RATE_W-1:0];
            REG_TPD:       tpd_ff       <= csr_data[TPD_W-1:0];
            REG_SLOTS:     slots_ff     <= csr_data[COUNT_W-1:0];
            REG_THRESHOLD: threshold_ff <= csr_data[COUNT_W-1:0];
            REG_ACC_EMPTY: acc_empty_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // clamp to the usable ranges
   always_comb begin
      cfg_out.bitrate = bitrate_ff;
      if (bitrate_ff == '0) cfg_out.bitrate = RATE_W'(1);
      else if (bitrate_ff > RATE_MAX) cfg_out.bitrate = RATE_MAX;

      cfg_out.tpd = tpd_ff;
      if (tpd_ff == '0) cfg_out.tpd = TPD_W'(1);
      else if (tpd_ff > TPD_W'(MAX_TS_PER_DATAGRAM)) cfg_out.tpd = TPD_W'(MAX_TS_PER_DATAGRAM);

      cfg_out.slots = slots_ff;
      if (slots_ff < COUNT_W'(2)) cfg_out.slots = COUNT_W'(2);
      else if (slots_ff > COUNT_W'(CAPACITY)) cfg_out.slots = COUNT_W'(CAPACITY);

      cfg_out.threshold = threshold_ff;
      cfg_out.acc_empty = acc_empty_ff;
   end

endmodule

// ===== sv/tscbr_ctrl.sv =====
module tscbr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_operation,
   input  tscbr_pkg::status_type  status,
   output tscbr_pkg::cmd_type     cmd,
   output logic                   busy
);
   import tscbr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_operation == OP_TICK) ? ST_MUL : ST_ARRIVE;
            end
         end
         ST_ARRIVE: state_in = ST_IDLE;
         ST_MUL:    state_in = ST_ADD;
         ST_ADD:    state_in = ST_DECIDE;
         ST_DECIDE: state_in = status.credit_pos ? ST_SEND : ST_IDLE;
         ST_SEND: begin
            if (status.send_last) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      busy       = (state_ff != ST_IDLE);
      cmd.load   = (state_ff == ST_IDLE) && start;
      cmd.arrive = (state_ff == ST_ARRIVE);
      cmd.mul    = (state_ff == ST_MUL);
      cmd.add    = (state_ff == ST_ADD);
      cmd.decide = (state_ff == ST_DECIDE);
      cmd.send   = (state_ff == ST_SEND);
   end

endmodule

// ===== sv/tscbr_datapath.sv =====
module tscbr_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  tscbr_pkg::cfg_type                  cfg,
   input  tscbr_pkg::cmd_type                  cmd,
   output tscbr_pkg::status_type               status,
   input  logic [tscbr_pkg::US_W-1:0]          req_elapsed_us,
   input  logic                                req_source_drained,
   output logic                                rsp_strobe,
   output logic [1:0]                          rsp_result_kind,
   output logic [tscbr_pkg::SLOT_W-1:0]        rsp_slot,
   output logic                                rsp_accepted,
   output logic [31:0]                         rsp_null_header,
   output logic                                rsp_last_in_datagram,
   output logic [tscbr_pkg::COUNT_W-1:0]       rsp_fill_count,
   output logic                                rsp_ready_res
);
   import tscbr_pkg::*;

   logic [SLOT_W-1:0]   wi_ff, wi_in;
   logic [SLOT_W-1:0]   ri_ff, ri_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic                rdy_ff, rdy_in;
   logic [CREDIT_W-1:0] credit_ff, credit_in;

   logic [US_W-1:0]     us_ff, us_in;
   logic                drained_ff, drained_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                cached_ff, cached_in;
   logic [TPD_W-1:0]    idx_ff, idx_in;

   logic                strobe_ff, strobe_in;
   logic [1:0]          kind_ff, kind_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                acc_ff, acc_in;
   logic [31:0]         hdr_ff, hdr_in;
   logic                last_ff, last_in;
   logic [COUNT_W-1:0]  fill_ff, fill_in;
   logic                rres_ff, rres_in;

   logic [COUNT_W:0]    cnt_inc;
   logic [COUNT_W-1:0]  cnt_dec;
   logic [SLOT_W:0]     wi_next, ri_next;
   logic [CREDIT_W:0]   credit_sum;
   logic [COST_W-1:0]   cost;
   logic                credit_pos;
   logic                idx_end;
   logic                send_last;

   assign cnt_inc    = {1'b0, cnt_ff} + (COUNT_W+1)'(1);
   assign cnt_dec    = cnt_ff - COUNT_W'(1);
   assign wi_next    = {1'b0, wi_ff} + (SLOT_W+1)'(1);
   assign ri_next    = {1'b0, ri_ff} + (SLOT_W+1)'(1);
   assign credit_sum = {credit_ff[CREDIT_W-1], credit_ff}
                     + {{(CREDIT_W+1-PROD_W){1'b0}}, prod_ff};
   assign cost       = COST_W'(cfg.tpd * TS_COST);
   assign credit_pos = !credit_ff[CREDIT_W-1] && (credit_ff != '0);
   assign idx_end    = ((idx_ff + TPD_W'(1)) == cfg.tpd);
   assign send_last  = cached_ff ? (idx_end || (cnt_dec == '0)) : idx_end;

   assign status.credit_pos = credit_pos;
   assign status.send_last  = send_last;

   always_comb begin
      wi_in      = wi_ff;
      ri_in      = ri_ff;
      cnt_in     = cnt_ff;
      rdy_in     = rdy_ff;
      credit_in  = credit_ff;
      us_in      = us_ff;
      drained_in = drained_ff;
      prod_in    = prod_ff;
      cached_in  = cached_ff;
      idx_in     = idx_ff;

      strobe_in  = 1'b0;
      kind_in    = kind_ff;
      slot_in    = slot_ff;
      acc_in     = acc_ff;
      hdr_in     = hdr_ff;
      last_in    = last_ff;
      fill_in    = fill_ff;
      rres_in    = rres_ff;

      if (cmd.load) begin
         // drop indices left stale by a smaller ring size
         us_in      = req_elapsed_us;
         drained_in = req_source_drained;
         if ({1'b0, wi_ff} >= cfg.slots) wi_in = '0;
         if ({1'b0, ri_ff} >= cfg.slots) ri_in = '0;
      end

      if (cmd.arrive) begin
         strobe_in = 1'b1;
         kind_in   = KIND_REPLY;
         hdr_in    = '0;
         last_in   = 1'b0;
         if (cnt_inc >= {1'b0, cfg.slots}) begin
            slot_in = '0;
            acc_in  = 1'b0;
            fill_in = cnt_ff;
            rres_in = rdy_ff;
         end else begin
            slot_in = wi_ff;
            acc_in  = 1'b1;
            wi_in   = (wi_next >= {1'b0, cfg.slots}) ? '0 : wi_next[SLOT_W-1:0];
            cnt_in  = cnt_inc[COUNT_W-1:0];
            if (cnt_inc[COUNT_W-1:0] > cfg.threshold) rdy_in = 1'b1;
            fill_in = cnt_inc[COUNT_W-1:0];
            rres_in = rdy_in;
         end
      end

      if (cmd.mul) begin
         prod_in = PROD_W'(us_ff * cfg.bitrate);
      end

      if (cmd.add) begin
         // credit only grows here, so only the top bound can be hit
         if (credit_sum[CREDIT_W:CREDIT_W-1] == 2'b01) begin
            credit_in = {1'b0, {(CREDIT_W-1){1'b1}}};
         end else begin
            credit_in = credit_sum[CREDIT_W-1:0];
         end
      end

      if (cmd.decide && credit_pos) begin
         // credit is positive, so charging the full datagram cannot underflow
         credit_in = credit_ff - {{(CREDIT_W-COST_W){1'b0}}, cost};
         cached_in = (rdy_ff || drained_ff) && (cnt_ff != '0);
         idx_in    = '0;
      end

      if (cmd.send) begin
         strobe_in = 1'b1;
         acc_in    = 1'b0;
         last_in   = send_last;
         idx_in    = idx_ff + TPD_W'(1);
         if (cached_ff) begin
            kind_in = KIND_CACHED;
            slot_in = ri_ff;
            hdr_in  = '0;
            ri_in   = (ri_next >= {1'b0, cfg.slots}) ? '0 : ri_next[SLOT_W-1:0];
            cnt_in  = cnt_dec;
            if ((cnt_dec == '0) && cfg.acc_empty) rdy_in = 1'b0;
            fill_in = cnt_dec;
            rres_in = rdy_in;
         end else begin
            kind_in = KIND_NULL;
            slot_in = '0;
            hdr_in  = NULL_WORD;
            fill_in = cnt_ff;
            rres_in = rdy_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wi_ff     <= '0;
         ri_ff     <= '0;
         cnt_ff    <= '0;
         rdy_ff    <= 1'b0;
         credit_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         wi_ff     <= wi_in;
         ri_ff     <= ri_in;
         cnt_ff    <= cnt_in;
         rdy_ff    <= rdy_in;
         credit_ff <= credit_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      us_ff      <= us_in;
      drained_ff <= drained_in;
      prod_ff    <= prod_in;
      cached_ff  <= cached_in;
      idx_ff     <= idx_in;
      kind_ff    <= kind_in;
      slot_ff    <= slot_in;
      acc_ff     <= acc_in;
      hdr_ff     <= hdr_in;
      last_ff    <= last_in;
      fill_ff    <= fill_in;
      rres_ff    <= rres_in;
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_result_kind      = kind_ff;
   assign rsp_slot             = slot_ff;
   assign rsp_accepted         = acc_ff;
   assign rsp_null_header      = hdr_ff;
   assign rsp_last_in_datagram = last_ff;
   assign rsp_fill_count       = fill_ff;
   assign rsp_ready_res        = rres_ff;

endmodule

// ===== sv/ts_cbr_pacer_with_null_stuffing_top.sv =====
// Constant-bitrate pacer for transport packets with null stuffing.
// Issue a word on the req_ ports with start; it is taken when busy is low.
// An arrival (req_operation 0) yields one reply word: granted ring slot or
// refusal, with the fill count and ready flag that follow it.
// A tick (req_operation 1) adds req_elapsed_us * bitrate to the send credit;
// if the credit is then positive, a datagram of up to ts_per_datagram words
// follows (cached slots, or null packets), one word per cycle.
// Results appear on the rsp_ ports for one cycle each, marked by rsp_strobe;
// the receiver cannot stall, and none is needed.
// Arrival: the ARRIVE state builds the reply and the rsp_ registers hold it;
// a new word is taken only once the block is back in idle.
// Tick: credit work runs through the latch, the MUL, ADD and DECIDE states
// (10x30 multiply, saturating add, charge), then SEND issues the results.
// Configuration writes on the csr_ channel are always ready and must land
// while the block is idle. Synchronous reset clears the ring state, the
// credit and the strobe, and loads the register defaults.
module ts_cbr_pacer_with_null_stuffing_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_operation,
   input  logic [tscbr_pkg::US_W-1:0]          req_elapsed_us,
   input  logic                                req_source_drained,
   output logic                                rsp_strobe,
   output logic [1:0]                          rsp_result_kind,
   output logic [tscbr_pkg::SLOT_W-1:0]        rsp_slot,
   output logic                                rsp_accepted,
   output logic [31:0]                         rsp_null_header,
   output logic                                rsp_last_in_datagram,
   output logic [tscbr_pkg::COUNT_W-1:0]       rsp_fill_count,
   output logic                                rsp_ready_res,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tscbr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tscbr_pkg::CSR_DATA_W-1:0]    csr_data
);
   import tscbr_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   tscbr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg_out   (cfg)
   );

   tscbr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy)
   );

   tscbr_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .cmd                  (cmd),
      .status               (status),
      .req_elapsed_us       (req_elapsed_us),
      .req_source_drained   (req_source_drained),
      .rsp_strobe           (rsp_strobe),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_slot             (rsp_slot),
      .rsp_accepted         (rsp_accepted),
      .rsp_null_header      (rsp_null_header),
      .rsp_last_in_datagram (rsp_last_in_datagram),
      .rsp_fill_count       (rsp_fill_count),
      .rsp_ready_res        (rsp_ready_res)
   );

endmodule
